>>> rtl/motor_duty_slew_pwm_top_assert.svh
// Assertion macros for the checker file of the duty slew block.
`ifndef MOTOR_DUTY_SLEW_PWM_TOP_ASSERT_SVH
`define MOTOR_DUTY_SLEW_PWM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define MDSP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdsp assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define MDSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdsp assertion failed");

`endif

>>> rtl/mdsp_pkg.sv
// Shared types and constants of the motor duty slew and PWM block.
`default_nettype none

package mdsp_pkg;

	localparam int FULL_SCALE   = 16384;
	localparam int HALF_SCALE   = FULL_SCALE / 2;
	localparam int FRAC_BITS    = 14;

	localparam logic [14:0] MAX_STEP_RESET   = 15'd328;
	localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;

	localparam logic [1:0] MODE_COAST   = 2'd0;
	localparam logic [1:0] MODE_STANDBY = 2'd1;

	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_TICK = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_MAX_STEP   = 2'd0,
		REG_PWM_PERIOD = 2'd1,
		REG_POLARITY   = 2'd2
	} cfg_reg_t;

	localparam logic signed [1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [1:0] DIR_REV  = 2'sb11;
	localparam logic signed [1:0] DIR_NONE = 2'sb00;

endpackage

`default_nettype wire

>>> rtl/motor_duty_slew_pwm_top.sv
// Top level of the slew-limited signed motor duty block with PWM compare output.
`default_nettype none

// Each input word (set target, tick, stop) yields one result word. A word is held in
// the input register, where the slew step, the |duty| x period multiply, rounding and clamp
// run in a single pass; the result is registered in the output register as the word leaves,
// and one word is taken every cycle while the output side keeps up. The duty
// state is updated as a word leaves the input register, so the next word always sees it.
// Configuration (max_step, pwm_period, polarity_invert) is always ready and is meant to be
// written while no word is in flight.
module motor_duty_slew_pwm_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [15:0] duty_request,
	input  logic [1:0]         mode_request,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [1:0]  direction,
	output logic [15:0]        compare_count,
	output logic signed [15:0] duty_now,
	output logic [1:0]         halt_mode
);

	logic [14:0]        max_step_q;
	logic [15:0]        pwm_period_q;
	logic               polarity_q;

	logic signed [15:0] target_q;
	logic signed [15:0] applied_q;
	logic [1:0]         held_mode_q;

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic signed [15:0] duty_s1;
	logic [1:0]         mode_s1;

	logic               out_valid_q;
	logic               status_q;
	logic signed [1:0]  direction_q;
	logic [15:0]        counts_q;
	logic signed [15:0] applied_out_q;
	logic [1:0]         mode_out_q;

	logic               adv;
	logic               fire;

	logic signed [17:0] cur_x;
	logic signed [17:0] tgt_x;
	logic signed [17:0] step_x;
	logic signed [17:0] diff;
	logic signed [17:0] slewed;
	logic signed [15:0] tick_level;
	logic [15:0]        neg_level;
	logic [14:0]        mag;
	logic [31:0]        prod;
	logic [17:0]        counts_raw;
	logic [15:0]        tick_counts;
	logic signed [1:0]  tick_dir;
	logic               out_of_range;

	logic signed [15:0] nxt_target;
	logic signed [15:0] nxt_applied;
	logic [1:0]         nxt_mode;
	logic               r_status;
	logic signed [1:0]  r_dir;
	logic [15:0]        r_counts;

	assign cfg_ready = 1'b1;

	// Output register frees when empty or being taken; input register moves with it.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q   <= mdsp_pkg::MAX_STEP_RESET;
			pwm_period_q <= mdsp_pkg::PWM_PERIOD_RESET;
			polarity_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mdsp_pkg::REG_MAX_STEP:   max_step_q   <= cfg_data[14:0];
				mdsp_pkg::REG_PWM_PERIOD: pwm_period_q <= cfg_data;
				mdsp_pkg::REG_POLARITY:   polarity_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Slew toward the target by at most max_step.
	always_comb begin
		cur_x  = {{2{applied_q[15]}}, applied_q};
		tgt_x  = {{2{target_q[15]}}, target_q};
		step_x = {3'b000, max_step_q};
		diff   = tgt_x - cur_x;
		if (diff > step_x) begin
			slewed = cur_x + step_x;
		end else if (diff < -step_x) begin
			slewed = cur_x - step_x;
		end else begin
			slewed = tgt_x;
		end
		tick_level = slewed[15:0];
	end

	// Round |duty| x period / full scale, half up, then clamp to the period.
	always_comb begin
		neg_level   = 16'(-tick_level);
		mag         = tick_level[15] ? neg_level[14:0] : tick_level[14:0];
		prod        = 32'(mag) * 32'(pwm_period_q) + 32'(mdsp_pkg::HALF_SCALE);
		counts_raw  = prod[31:mdsp_pkg::FRAC_BITS];
		tick_counts = (counts_raw > {2'b00, pwm_period_q}) ? pwm_period_q : counts_raw[15:0];
		if (tick_level == 16'sd0) begin
			tick_dir    = mdsp_pkg::DIR_NONE;
			tick_counts = 16'd0;
		end else if (tick_level[15] ^ polarity_q) begin
			tick_dir = mdsp_pkg::DIR_REV;
		end else begin
			tick_dir = mdsp_pkg::DIR_FWD;
		end
	end

	assign out_of_range = (duty_s1 < -16'(mdsp_pkg::FULL_SCALE))
		|| (duty_s1 > 16'(mdsp_pkg::FULL_SCALE));

	always_comb begin
		nxt_target  = target_q;
		nxt_applied = applied_q;
		nxt_mode    = held_mode_q;
		r_status    = 1'b0;
		r_dir       = mdsp_pkg::DIR_NONE;
		r_counts    = 16'd0;
		case (action_s1)
			mdsp_pkg::ACT_SET: begin
				if (out_of_range) begin
					nxt_target  = 16'sd0;
					nxt_applied = 16'sd0;
					nxt_mode    = mdsp_pkg::MODE_STANDBY;
					r_status    = 1'b1;
				end else begin
					nxt_target = duty_s1;
				end
			end
			mdsp_pkg::ACT_TICK: begin
				nxt_applied = tick_level;
				r_dir       = tick_dir;
				r_counts    = tick_counts;
			end
			mdsp_pkg::ACT_STOP: begin
				nxt_target  = 16'sd0;
				nxt_applied = 16'sd0;
				nxt_mode    = mode_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= 16'sd0;
			applied_q   <= 16'sd0;
			held_mode_q <= mdsp_pkg::MODE_COAST;
		end else if (fire) begin
			target_q    <= nxt_target;
			applied_q   <= nxt_applied;
			held_mode_q <= nxt_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			duty_s1   <= duty_request;
			mode_s1   <= mode_request;
		end
		if (fire) begin
			status_q      <= r_status;
			direction_q   <= r_dir;
			counts_q      <= r_counts;
			applied_out_q <= nxt_applied;
			mode_out_q    <= nxt_mode;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign direction     = direction_q;
	assign compare_count = counts_q;
	assign duty_now      = applied_out_q;
	assign halt_mode     = mode_out_q;

endmodule

`default_nettype wire

>>> rtl/mdsp_checker.sv
// Port-level checker for the duty slew block, bound to its top level.
`default_nettype none

`include "motor_duty_slew_pwm_top_assert.svh"

module mdsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               status,
	input logic signed [1:0]  direction,
	input logic [15:0]        compare_count,
	input logic signed [15:0] duty_now,
	input logic [1:0]         halt_mode
);

	// Hold a stalled result word.
	`MDSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(direction) && $stable(compare_count)
		&& $stable(duty_now) && $stable(halt_mode))

	// A range error drops to standby with both duties cleared.
	`MDSP_ASSERT_IMPL(a_err_standby, out_valid && status,
		duty_now == 16'sd0 && halt_mode == mdsp_pkg::MODE_STANDBY
		&& direction == mdsp_pkg::DIR_NONE && compare_count == 16'd0)

	// No drive direction means no compare counts.
	`MDSP_ASSERT_IMPL(a_idle_counts, out_valid && direction == mdsp_pkg::DIR_NONE,
		compare_count == 16'd0)

	// Applied duty never leaves full scale.
	`MDSP_ASSERT_IMPL(a_duty_range, out_valid,
		duty_now >= -16'(mdsp_pkg::FULL_SCALE) && duty_now <= 16'(mdsp_pkg::FULL_SCALE))

endmodule

bind motor_duty_slew_pwm_top mdsp_checker u_mdsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.direction     (direction),
	.compare_count (compare_count),
	.duty_now      (duty_now),
	.halt_mode     (halt_mode)
);

`default_nettype wire

>>> test/motor_duty_slew_pwm_tb.sv
// Self-checking testbench for the slew-limited motor duty and PWM compare block.
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         HOLDOFF_LEN  = 300;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         SHOWN_ERRORS = 10;

	typedef struct packed {
		logic [1:0]         act;
		logic signed [15:0] duty;
		logic [1:0]         mode;
	} duty_cmd_t;

	typedef struct packed {
		logic               status;
		logic signed [1:0]  direction;
		logic [15:0]        counts;
		logic signed [15:0] applied;
		logic [1:0]         halt_mode;
	} drive_word_t;

	typedef struct packed {
		mdsp_pkg::cfg_reg_t idx;
		logic [15:0]        data;
	} reg_write_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         action = '0;
	logic signed [15:0] duty_request = '0;
	logic [1:0]         mode_request = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               status;
	logic signed [1:0]  direction;
	logic [15:0]        compare_count;
	logic signed [15:0] duty_now;
	logic [1:0]         halt_mode;

	duty_cmd_t   cmd_queue[$];
	drive_word_t drive_expect_q[$];
	reg_write_t  reg_queue[$];

	// predictor copy of registers and duty state
	logic [14:0]        step_lim = mdsp_pkg::MAX_STEP_RESET;
	logic [15:0]        period_lim = mdsp_pkg::PWM_PERIOD_RESET;
	logic               invert_dir = 1'b0;
	logic signed [15:0] target_lvl = '0;
	logic signed [15:0] applied_lvl = '0;
	logic [1:0]         held_mode = mdsp_pkg::MODE_COAST;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	logic holdoff_go = 1'b0;
	int holdoff_cnt = 0;
	logic holding;

	motor_duty_slew_pwm_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.duty_request (duty_request),
		.mode_request (mode_request),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.direction    (direction),
		.compare_count(compare_count),
		.duty_now     (duty_now),
		.halt_mode    (halt_mode)
	);

	always #1 clk = ~clk;

	function automatic drive_word_t apply_cmd(input duty_cmd_t cmd);
		drive_word_t w;
		int diff;
		int lvl;
		int mag;
		longint prod;
		w = '0;
		case (cmd.act)
			mdsp_pkg::ACT_SET: begin
				if (cmd.duty < -mdsp_pkg::FULL_SCALE || cmd.duty > mdsp_pkg::FULL_SCALE) begin
					target_lvl = '0;
					applied_lvl = '0;
					held_mode = mdsp_pkg::MODE_STANDBY;
					w.status = 1'b1;
				end else begin
					target_lvl = cmd.duty;
				end
			end
			mdsp_pkg::ACT_TICK: begin
				diff = int'(target_lvl) - int'(applied_lvl);
				if (diff > int'(step_lim))
					lvl = int'(applied_lvl) + int'(step_lim);
				else if (diff < -int'(step_lim))
					lvl = int'(applied_lvl) - int'(step_lim);
				else
					lvl = int'(target_lvl);
				applied_lvl = lvl[15:0];
				if (lvl != 0) begin
					w.direction = ((lvl > 0) != invert_dir)
						? mdsp_pkg::DIR_FWD : mdsp_pkg::DIR_REV;
					mag = (lvl > 0) ? lvl : -lvl;
					// round half up, then clamp to the period
					prod = (longint'(mag) * longint'(period_lim) + mdsp_pkg::HALF_SCALE)
						>>> mdsp_pkg::FRAC_BITS;
					if (prod > longint'(period_lim))
						prod = longint'(period_lim);
					w.counts = prod[15:0];
				end
			end
			mdsp_pkg::ACT_STOP: begin
				target_lvl = '0;
				applied_lvl = '0;
				held_mode = cmd.mode;
			end
			default: begin
			end
		endcase
		w.applied = applied_lvl;
		w.halt_mode = held_mode;
		return w;
	endfunction

	// command driver: predict on accept, then offer the next word
	always @(posedge clk) begin : drive_cmds
		duty_cmd_t next_cmd;
		if (in_valid && in_ready)
			drive_expect_q.push_back(apply_cmd(duty_cmd_t'{action, duty_request, mode_request}));
		if (!in_valid || in_ready) begin
			if (arst_n && cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = cmd_queue.pop_front();
				action <= next_cmd.act;
				duty_request <= next_cmd.duty;
				mode_request <= next_cmd.mode;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// register write driver
	always @(posedge clk) begin : drive_regs
		reg_write_t wr;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mdsp_pkg::REG_MAX_STEP:   step_lim <= cfg_data[14:0];
				mdsp_pkg::REG_PWM_PERIOD: period_lim <= cfg_data;
				mdsp_pkg::REG_POLARITY:   invert_dir <= cfg_data[0];
				default: begin
				end
			endcase
		end
		if (!cfg_valid || cfg_ready) begin
			if (arst_n && reg_queue.size() != 0) begin
				wr = reg_queue.pop_front();
				cfg_index <= wr.idx;
				cfg_data <= wr.data;
				cfg_valid <= 1'b1;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk)
		if (holdoff_go && holdoff_cnt < HOLDOFF_LEN)
			holdoff_cnt <= holdoff_cnt + 1;

	assign holding = holdoff_go && holdoff_cnt < HOLDOFF_LEN;

	// result monitor
	always @(posedge clk) begin : watch_results
		drive_word_t got;
		drive_word_t want;
		out_ready <= !holding && ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			got = '{status, direction, compare_count, duty_now, halt_mode};
			if (drive_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("unexpected word: status %0d dir %0d counts %0d duty %0d mode %0d",
						got.status, got.direction, got.counts, got.applied, got.halt_mode);
			end else begin
				want = drive_expect_q.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display({"mismatch: status %0d/%0d dir %0d/%0d counts %0d/%0d ",
							"duty %0d/%0d mode %0d/%0d (expected/actual)"},
							want.status, got.status, want.direction, got.direction,
							want.counts, got.counts, want.applied, got.applied,
							want.halt_mode, got.halt_mode);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_cmd(input logic [1:0] act, input logic signed [15:0] duty,
			input logic [1:0] mode);
		cmd_queue.push_back(duty_cmd_t'{act, duty, mode});
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || drive_expect_q.size() != 0);
	endtask

	// write all three registers while nothing is in flight
	task automatic set_regs(input int step, input int period, input bit pol);
		wait_drained();
		reg_queue.push_back(reg_write_t'{mdsp_pkg::REG_MAX_STEP, {1'($urandom), 15'(step)}});
		reg_queue.push_back(reg_write_t'{mdsp_pkg::REG_PWM_PERIOD, 16'(period)});
		reg_queue.push_back(reg_write_t'{mdsp_pkg::REG_POLARITY, {15'($urandom), pol}});
		do
			@(negedge clk);
		while (reg_queue.size() != 0 || cfg_valid);
	endtask

	function automatic logic signed [15:0] in_range_duty();
		int v;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = mdsp_pkg::FULL_SCALE;
				2: v = -mdsp_pkg::FULL_SCALE;
				3: v = mdsp_pkg::HALF_SCALE;
				4: v = -mdsp_pkg::HALF_SCALE;
				5: v = mdsp_pkg::HALF_SCALE - 1;
				6: v = 1;
				default: v = -1;
			endcase
		end else begin
			v = int'($urandom_range(2 * mdsp_pkg::FULL_SCALE)) - mdsp_pkg::FULL_SCALE;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] out_of_range_duty();
		int v;
		do
			v = int'($urandom_range(65535)) - 32768;
		while (v >= -mdsp_pkg::FULL_SCALE && v <= mdsp_pkg::FULL_SCALE);
		return v[15:0];
	endfunction

	// mostly set-then-ramp sequences, with stops, range errors and stray codes mixed in
	task automatic run_burst(input int n, input int idle_pct, input int stall_v);
		int pushed;
		int k;
		int pick;
		send_idle_pct = idle_pct;
		stall_pct = stall_v;
		pushed = 0;
		while (pushed < n) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				push_cmd(mdsp_pkg::ACT_SET, in_range_duty(), 2'($urandom));
				k = $urandom_range(1, 24);
				repeat (k)
					push_cmd(mdsp_pkg::ACT_TICK, 16'($urandom), 2'($urandom));
				pushed += k + 1;
			end else begin
				if (pick < 75)
					push_cmd(mdsp_pkg::ACT_STOP, 16'($urandom), 2'($urandom));
				else if (pick < 83)
					push_cmd(mdsp_pkg::ACT_SET, out_of_range_duty(), 2'($urandom));
				else if (pick < 87)
					push_cmd(ACT_UNUSED, 16'($urandom), 2'($urandom));
				else
					push_cmd(mdsp_pkg::ACT_TICK, 16'($urandom), 2'($urandom));
				pushed++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_regs(mdsp_pkg::HALF_SCALE, 1000, 1'b0);
		push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'(mdsp_pkg::FULL_SCALE), mdsp_pkg::MODE_COAST);
		repeat (3)
			push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'(-mdsp_pkg::FULL_SCALE), mdsp_pkg::MODE_COAST);
		repeat (4)
			push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'(mdsp_pkg::FULL_SCALE + 1), mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'(-mdsp_pkg::FULL_SCALE - 1), mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'h7fff, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'h8000, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_SET, 16'sd3, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);
		for (int m = 0; m < 4; m++)
			push_cmd(mdsp_pkg::ACT_STOP, 16'sd0, 2'(m));
		push_cmd(ACT_UNUSED, 16'hffff, 2'd3);
		push_cmd(mdsp_pkg::ACT_TICK, 16'hffff, 2'd3);
		push_cmd(mdsp_pkg::ACT_SET, -16'sd1, mdsp_pkg::MODE_COAST);
		push_cmd(mdsp_pkg::ACT_TICK, 16'sd0, mdsp_pkg::MODE_COAST);

		set_regs(1, 65535, 1'b1);
		run_burst(225, 0, 0);
		set_regs(mdsp_pkg::FULL_SCALE, 1, 1'b0);
		run_burst(225, 80, 0);
		set_regs(32767, 0, 1'b1);
		run_burst(225, 0, 80);
		set_regs(0, 12345, 1'b0);
		run_burst(225, 23, 23);

		// drop ready for a long stretch while words keep coming
		set_regs($urandom_range(1, mdsp_pkg::FULL_SCALE), $urandom_range(1, 65535),
			1'($urandom));
		run_burst(225, 0, 0);
		@(posedge clk);
		holdoff_go <= 1'b1;

		set_regs($urandom_range(1, 2000), 1000, 1'b1);
		run_burst(110, 23, 23);
		wait_drained();
		run_burst(115, 23, 23);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && drive_expect_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
